### hw/rtl/lspl_pkg.sv
// Package for the light sensor piecewise linearizer.
// Holds widths, the shared divider request/response structs, the state enum
// and the calibration ROM functions. No dependencies.
package lspl_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned CodeW   = 10;
  localparam int unsigned VoltW   = 16;
  localparam int unsigned LuxInW  = 16;
  localparam int unsigned LuxW    = 17;
  localparam int unsigned SegW    = 6;

  // Calibration table size and defaults.
  localparam int unsigned RomDepth         = 40;
  localparam int unsigned TablePointsDflt  = 40;
  localparam logic [LuxW-1:0] LuxMax       = 17'h1FFFF;

  // Voltage scaling: v = round(code * 40960 / 1023).
  localparam logic [VoltW-1:0] AdcFull     = 16'd1023;
  localparam logic [VoltW-1:0] AdcHalf     = 16'd511;

  // Divider widths.
  localparam int unsigned DivW    = 36;  // dividend and quotient
  localparam int unsigned DvsW    = 17;  // divisor and remainder
  localparam int unsigned DivCntW = 6;

  // Interpolation arithmetic widths.
  localparam int unsigned DiffW = 17;    // signed difference of two table values
  localparam int unsigned ProdW = 34;    // signed product of two differences
  localparam int unsigned NumW  = 37;    // signed rounding numerator

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [DvsW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DivW-1:0]   quotient;
    logic [DvsW-1:0]   remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SEARCH,
    ST_LOAD0,
    ST_LOAD1,
    ST_MUL,
    ST_NUM,
    ST_ISTART,
    ST_IWAIT,
    ST_SUM
  } lspl_state_e;

  // Breakpoint voltages, unsigned Q3.13.
  function automatic logic [VoltW-1:0] volt_rom(input logic [SegW-1:0] addr);
    logic [VoltW-1:0] val;
    unique case (addr)
      6'd0:  val = 16'd57;
      6'd1:  val = 16'd74;
      6'd2:  val = 16'd98;
      6'd3:  val = 16'd131;
      6'd4:  val = 16'd172;
      6'd5:  val = 16'd229;
      6'd6:  val = 16'd303;
      6'd7:  val = 16'd401;
      6'd8:  val = 16'd524;
      6'd9:  val = 16'd696;
      6'd10: val = 16'd918;
      6'd11: val = 16'd1204;
      6'd12: val = 16'd1589;
      6'd13: val = 16'd2073;
      6'd14: val = 16'd2712;
      6'd15: val = 16'd3514;
      6'd16: val = 16'd4538;
      6'd17: val = 16'd5808;
      6'd18: val = 16'd7356;
      6'd19: val = 16'd9208;
      6'd20: val = 16'd11370;
      6'd21: val = 16'd13812;
      6'd22: val = 16'd16474;
      6'd23: val = 16'd19276;
      6'd24: val = 16'd22110;
      6'd25: val = 16'd24871;
      6'd26: val = 16'd27451;
      6'd27: val = 16'd29778;
      6'd28: val = 16'd31818;
      6'd29: val = 16'd33546;
      6'd30: val = 16'd34972;
      6'd31: val = 16'd36135;
      6'd32: val = 16'd37061;
      6'd33: val = 16'd37798;
      6'd34: val = 16'd38363;
      6'd35: val = 16'd38806;
      6'd36: val = 16'd39150;
      6'd37: val = 16'd39404;
      6'd38: val = 16'd39600;
      6'd39: val = 16'd39748;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Breakpoint illuminances, unsigned Q8.8.
  function automatic logic [LuxInW-1:0] lux_rom(input logic [SegW-1:0] addr);
    logic [LuxInW-1:0] val;
    unique case (addr)
      6'd0:  val = 16'd26;
      6'd1:  val = 16'd31;
      6'd2:  val = 16'd37;
      6'd3:  val = 16'd44;
      6'd4:  val = 16'd53;
      6'd5:  val = 16'd64;
      6'd6:  val = 16'd77;
      6'd7:  val = 16'd92;
      6'd8:  val = 16'd110;
      6'd9:  val = 16'd132;
      6'd10: val = 16'd158;
      6'd11: val = 16'd190;
      6'd12: val = 16'd228;
      6'd13: val = 16'd274;
      6'd14: val = 16'd329;
      6'd15: val = 16'd394;
      6'd16: val = 16'd473;
      6'd17: val = 16'd568;
      6'd18: val = 16'd681;
      6'd19: val = 16'd818;
      6'd20: val = 16'd982;
      6'd21: val = 16'd1178;
      6'd22: val = 16'd1413;
      6'd23: val = 16'd1696;
      6'd24: val = 16'd2035;
      6'd25: val = 16'd2442;
      6'd26: val = 16'd2931;
      6'd27: val = 16'd3517;
      6'd28: val = 16'd4219;
      6'd29: val = 16'd5064;
      6'd30: val = 16'd6077;
      6'd31: val = 16'd7293;
      6'd32: val = 16'd8750;
      6'd33: val = 16'd10501;
      6'd34: val = 16'd12600;
      6'd35: val = 16'd15122;
      6'd36: val = 16'd18145;
      6'd37: val = 16'd21775;
      6'd38: val = 16'd26138;
      6'd39: val = 16'd31360;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/light_sensor_piecewise_linearizer_core.sv
// Top level of the light sensor piecewise linearizer: sequencer, table
// search and interpolation datapath. Depends on lspl_pkg and lspl_div.
//
//   Channel  Dir  Fields (from bit 0 up)
//   s_axis   in   tdata: adc_code[9:0], zero pad to 16 bits
//   m_axis   out  tdata: lux_level[16:0], segment_index[22:17], pad to 24 bits
//                 tuser: extrapolated
//
// The time from one input transfer to the next possible one grows with k,
// the search steps (1 .. number of breakpoints in use); a flat segment
// skips the divide. The time is set by the bit-serial divider (36 steps
// for the interpolation) and the search that reads one breakpoint a cycle.
// Reset returns the sequencer to idle and empties the output register. A
// stalled result waits in the output register while the next input item is
// taken; that item then holds in its last step until the output register
// is free.
module light_sensor_piecewise_linearizer_core
  import lspl_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = TablePointsDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // adc_code[9:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // lux_level[16:0], segment_index[22:17]
  output logic        m_axis_tuser    // extrapolated
);

  localparam int unsigned PointsUsed =
      (TABLE_POINTS < RomDepth) ? ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS) : RomDepth;
  localparam logic [SegW-1:0] LastIdx = SegW'(PointsUsed - 1);

  lspl_state_e state_q, state_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CodeW-1:0]        code_q;
  logic [VoltW-1:0]        volt_q;
  logic [SegW-1:0]         idx_q;
  logic [SegW-1:0]         seg_q;
  logic                    hi_q, lo_q;
  logic [VoltW-1:0]        v0_q, v1_q;
  logic [LuxInW-1:0]       l0_q, l1_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DiffW-1:0] den_q;
  logic                    flat_q;
  logic                    nneg_q;
  logic [DivW-1:0]         nmag_q;
  logic signed [NumW-1:0]  quo_q;
  logic                    out_valid_q;
  logic [LuxW-1:0]         out_lux_q;
  logic [SegW-1:0]         out_seg_q;
  logic                    out_ext_q;

  logic [SegW-1:0]         rom_addr;
  logic [VoltW-1:0]        rom_v;
  logic [LuxInW-1:0]       rom_l;
  logic [VoltW-1:0]        code40;
  logic [VoltW-1:0]        scale_num;
  logic [VoltW-1:0]        scale_rem;
  logic [VoltW-1:0]        scale_quo;
  logic                    search_lt;
  logic                    search_end;
  logic signed [DiffW-1:0] dv, dl, den_raw;
  logic [VoltW-1:0]        den_abs;
  logic signed [ProdW:0]   num_adj;
  logic signed [NumW-1:0]  num_rnd;
  logic [DivW:0]           quo_ext;
  logic signed [NumW:0]    lux_sum;
  logic [LuxW-1:0]         lux_sat;
  logic                    in_xfer;
  logic                    out_free;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Calibration table read port, one address a cycle.
  always_comb begin
    case (state_q)
      ST_LOAD0: rom_addr = seg_q;
      ST_LOAD1: rom_addr = seg_q + 1'b1;
      default:  rom_addr = idx_q;
    endcase
  end
  assign rom_v = volt_rom(rom_addr);
  assign rom_l = lux_rom(rom_addr);

  // Scaled code: code * 40 as shift and add, plus the rounded fraction
  // round(code * 40 / 1023).
  assign code40 = {1'b0, code_q, 5'b0} + {3'b0, code_q, 3'b0};

  // Divide by 1023 as a divide by 1024 with one correction step: the
  // quotient is at most 40, so the leftover stays below twice the divisor.
  assign scale_num = code40 + AdcHalf;
  assign scale_rem = {6'b0, scale_num[9:0]} + {10'b0, scale_num[15:10]};
  assign scale_quo = (scale_rem >= AdcFull) ? {10'b0, scale_num[15:10]} + 16'd1
                                            : {10'b0, scale_num[15:10]};

  // Downward search step: move on while the voltage lies below the entry.
  assign search_lt  = volt_q < rom_v;
  assign search_end = (idx_q == '0) || !search_lt;

  // Interpolation operands.
  assign dv      = $signed({1'b0, volt_q}) - $signed({1'b0, v0_q});
  assign dl      = $signed({1'b0, l1_q}) - $signed({1'b0, l0_q});
  assign den_raw = $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});

  // Rounding numerator 2*num + den with a positive denominator.
  always_comb begin
    logic [DiffW-1:0] den_tmp;
    den_tmp = den_q[DiffW-1] ? DiffW'(-den_q) : DiffW'(den_q);
    den_abs = den_tmp[VoltW-1:0];
    num_adj = den_q[DiffW-1] ? -(ProdW+1)'(prod_q) : (ProdW+1)'(prod_q);
    num_rnd = (NumW'(num_adj) <<< 1) + $signed({{(NumW-VoltW){1'b0}}, den_abs});
  end

  // Floor quotient: a negative numerator rounds away from zero on a remainder.
  always_comb begin
    quo_ext = {1'b0, div_rsp.quotient};
    if (nneg_q) begin
      quo_ext = (div_rsp.remainder != '0) ? ~quo_ext : (~quo_ext + 1'b1);
    end
  end

  // Final sum with clamp at zero and saturation at the field maximum.
  always_comb begin
    lux_sum = $signed({{(NumW+1-LuxInW){1'b0}}, l0_q}) + (NumW+1)'(quo_q);
    if (lux_sum < 0) begin
      lux_sat = '0;
    end else if (lux_sum > $signed({{(NumW+1-LuxW){1'b0}}, LuxMax})) begin
      lux_sat = LuxMax;
    end else begin
      lux_sat = lux_sum[LuxW-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_SEARCH;
      ST_SEARCH: if (search_end) state_d = ST_LOAD0;
      ST_LOAD0:  state_d = ST_LOAD1;
      ST_LOAD1:  state_d = ST_MUL;
      ST_MUL:    state_d = ST_NUM;
      ST_NUM:    state_d = (den_q == '0) ? ST_SUM : ST_ISTART;
      ST_ISTART: state_d = ST_IWAIT;
      ST_IWAIT:  if (div_rsp.done) state_d = ST_SUM;
      ST_SUM:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input handshake and divider commands.
  always_comb begin
    s_axis_tready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_ISTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = nmag_q;
        div_req.divisor  = {den_abs, 1'b0};
      end
      default: ;
    endcase
  end

  lspl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUM && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) code_q <= s_axis_tdata[CodeW-1:0];
      end
      ST_SCALE: begin
        volt_q <= code40 + scale_quo;
        idx_q  <= LastIdx;
      end
      ST_SEARCH: begin
        if (idx_q == LastIdx) hi_q <= volt_q > rom_v;
        if (search_end) begin
          seg_q <= (idx_q < LastIdx) ? idx_q : LastIdx - 1'b1;
          lo_q  <= (idx_q == '0) && search_lt;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
      ST_LOAD0: begin
        v0_q <= rom_v;
        l0_q <= rom_l;
      end
      ST_LOAD1: begin
        v1_q <= rom_v;
        l1_q <= rom_l;
      end
      ST_MUL: begin
        prod_q <= dv * dl;
        den_q  <= den_raw;
      end
      ST_NUM: begin
        flat_q <= den_q == '0;
        nneg_q <= num_rnd < 0;
        nmag_q <= (num_rnd < 0) ? DivW'(-num_rnd) : DivW'(num_rnd);
        quo_q  <= '0;
      end
      ST_IWAIT: begin
        if (div_rsp.done) quo_q <= NumW'(quo_ext);
      end
      ST_SUM: begin
        if (out_free) begin
          out_lux_q <= lux_sat;
          out_seg_q <= seg_q;
          out_ext_q <= hi_q || lo_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_seg_q, out_lux_q};
  assign m_axis_tuser  = out_ext_q;

  // The segment of a result lies inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> out_seg_q <= LastIdx - 1'b1)
    else $error("linearizer: segment index outside the table");

  // Extrapolation only happens on the bottom or top segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && out_ext_q) |-> (out_seg_q == '0 || out_seg_q == LastIdx - 1'b1))
    else $error("linearizer: extrapolation on an inner segment");

  // While waiting on the divider, a divide is really in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_IWAIT |-> (div_rsp.busy || div_rsp.done))
    else $error("linearizer: waiting on an idle divider");

  // A flat segment never reaches the interpolation divide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_ISTART |-> !flat_q)
    else $error("linearizer: divide started on a flat segment");

endmodule

### hw/rtl/lspl_div.sv
// Bit-serial restoring divider of the linearizer.
// Depends on lspl_pkg for widths and the request/response structs.
module lspl_div
  import lspl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    acc_q, acc_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW:0]      shifted;
  logic [DvsW:0]      trial;
  logic               fits;

  // One quotient bit per cycle: shift the next dividend bit into the
  // partial remainder and subtract the divisor where it fits.
  assign shifted = {rem_q, acc_q[DivW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      acc_d  = req_i.dividend;
      cnt_d  = DivCntW'(DivW);
    end else if (busy_q) begin
      acc_d = {acc_q[DivW-2:0], fits};
      rem_d = fits ? trial[DvsW-1:0] : shifted[DvsW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = acc_q;
  assign rsp_o.remainder = rem_q;

  // A new divide is only started while the unit is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("lspl_div: start while busy");

  // The done pulse lasts one cycle and follows the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q && $past(busy_q))
    else $error("lspl_div: done without a finished divide");

  // The final remainder is below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> rem_q < dvs_q)
    else $error("lspl_div: remainder not reduced");

endmodule

### bench/tb_top.sv
// Self-checking bench for light_sensor_piecewise_linearizer_core: streams ADC
// codes in bursts, predicts lux, segment and flag per code, and compares them.
// Depends on lspl_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import lspl_pkg::*;

  localparam int unsigned TablePoints = TablePointsDflt;
  localparam longint      VoltScale   = 40960;
  localparam int unsigned RandomCodes = 1800;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned CycleLimit  = 3000000;

  // One expected output transfer.
  typedef struct packed {
    logic [LuxW-1:0] lux;
    logic [SegW-1:0] seg;
    logic            extrap;
  } lux_reading_t;

  // Predicts the reading of each accepted code and checks results in order.
  class lux_tracker;
    lux_reading_t pending_lux[$];
    int unsigned  failures;
    int unsigned  pts_used;
    longint       volt_pts[RomDepth];
    longint       lux_pts[RomDepth];

    function new(int unsigned points);
      volt_pts = '{57, 74, 98, 131, 172, 229, 303, 401, 524, 696,
                   918, 1204, 1589, 2073, 2712, 3514, 4538, 5808, 7356, 9208,
                   11370, 13812, 16474, 19276, 22110, 24871, 27451, 29778, 31818,
                   33546, 34972, 36135, 37061, 37798, 38363, 38806, 39150, 39404,
                   39600, 39748};
      lux_pts  = '{26, 31, 37, 44, 53, 64, 77, 92, 110, 132,
                   158, 190, 228, 274, 329, 394, 473, 568, 681, 818,
                   982, 1178, 1413, 1696, 2035, 2442, 2931, 3517, 4219, 5064,
                   6077, 7293, 8750, 10501, 12600, 15122, 18145, 21775, 26138,
                   31360};
      pts_used = (points < 2) ? 2 : ((points > RomDepth) ? RomDepth : points);
      failures = 0;
    endfunction

    // Scale to volts, search the table from the top, then interpolate.
    function lux_reading_t linearize_code(logic [CodeW-1:0] code);
      longint       volts;
      longint       v0;
      longint       v1;
      longint       l0;
      longint       l1;
      longint       span;
      longint       num;
      longint       rnd;
      longint       lux;
      int           last;
      int           idx;
      int           seg;
      lux_reading_t r;
      volts = (longint'(code) * VoltScale + longint'(AdcHalf)) / longint'(AdcFull);
      last  = pts_used - 1;
      idx   = last;
      while (idx > 0 && volts < volt_pts[idx]) idx--;
      seg  = (idx < last) ? idx : last - 1;
      v0   = volt_pts[seg];
      v1   = volt_pts[seg + 1];
      l0   = lux_pts[seg];
      l1   = lux_pts[seg + 1];
      span = v1 - v0;
      if (span == 0) begin
        lux = l0;
      end else begin
        num = (volts - v0) * (l1 - l0);
        if (span < 0) begin
          span = -span;
          num  = -num;
        end
        // Round to nearest with ties toward plus infinity.
        rnd = 2 * num + span;
        if (rnd >= 0) begin
          lux = l0 + rnd / (2 * span);
        end else begin
          lux = l0 - ((-rnd + 2 * span - 1) / (2 * span));
        end
      end
      if (lux < 0) lux = 0;
      if (lux > longint'(LuxMax)) lux = longint'(LuxMax);
      r.lux    = lux[LuxW-1:0];
      r.seg    = seg[SegW-1:0];
      r.extrap = (volts < volt_pts[0] || volts > volt_pts[last]);
      return r;
    endfunction

    function void note_sample(logic [CodeW-1:0] code);
      pending_lux.push_back(linearize_code(code));
    endfunction

    function void check_reading(lux_reading_t got);
      lux_reading_t want;
      if (pending_lux.size() == 0) begin
        $error("unexpected result: lux_level %0d segment_index %0d extrapolated %0d",
               got.lux, got.seg, got.extrap);
        failures++;
        return;
      end
      want = pending_lux.pop_front();
      if (got.lux !== want.lux) begin
        $error("lux_level: expected %0d, actual %0d", want.lux, got.lux);
        failures++;
      end
      if (got.seg !== want.seg) begin
        $error("segment_index: expected %0d, actual %0d", want.seg, got.seg);
        failures++;
      end
      if (got.extrap !== want.extrap) begin
        $error("extrapolated: expected %0d, actual %0d", want.extrap, got.extrap);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // adc_code[9:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // lux_level[16:0], segment_index[22:17]
  logic        m_axis_tuser;        // extrapolated

  lux_tracker  tracker;
  int unsigned cycle_count = 0;

  // Ends of the range, both sides of the first and last breakpoints, mid codes.
  int unsigned corner_codes[22] = '{0, 1, 2, 3, 4, 5, 10, 100, 230, 255, 256, 511,
                                    512, 767, 768, 900, 960, 990, 992, 993, 1022, 1023};

  light_sensor_piecewise_linearizer_core #(
    .TABLE_POINTS(TablePoints)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Input transfers feed the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tracker.note_sample(s_axis_tdata[CodeW-1:0]);
    end
  end

  // Output transfers are checked against the oldest prediction.
  always @(posedge clk_i) begin : out_monitor
    lux_reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.lux    = m_axis_tdata[LuxW-1:0];
      got.seg    = m_axis_tdata[LuxW+SegW-1:LuxW];
      got.extrap = m_axis_tuser;
      tracker.check_reading(got);
    end
  end

  // Receiver backpressure: modes of always ready, coin flips, a periodic
  // stall and long runs of stall and ready.
  always @(posedge clk_i) begin : ready_pattern
    int unsigned ready_mode;
    int unsigned mode_left;
    int unsigned run_left;
    int unsigned tick;
    logic        run_val;
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 400);
    end
    mode_left--;
    tick++;
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (tick % 5) != 0;
      default: begin
        if (run_left == 0) begin
          // The run value starts unknown, so flip from a known level.
          run_val  = (run_val !== 1'b1);
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        m_axis_tready <= run_val;
      end
    endcase
  end

  // Offer one code and hold it until the transfer happens.
  task automatic send_code(input logic [CodeW-1:0] code);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16 - CodeW){1'b0}}, code};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid for a number of cycles; the data bus carries noise meanwhile.
  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Random codes lean toward the low range, where the breakpoints are dense.
  function automatic logic [CodeW-1:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return CodeW'($urandom_range(0, 1023));
    if (sel < 8) return CodeW'($urandom_range(0, 240));
    return CodeW'($urandom_range(950, 1023));
  endfunction

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned codes_left;
    int unsigned burst;
    int unsigned gap;
    tracker = new(TablePoints);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners, with short gaps between some of them.
    foreach (corner_codes[k]) begin
      send_code(corner_codes[k][CodeW-1:0]);
      idle_gap($urandom_range(0, 2));
    end

    // Random codes in bursts.
    codes_left = RandomCodes;
    while (codes_left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && codes_left > 0) begin
        send_code(pick_code());
        burst--;
        codes_left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
      idle_gap(gap);
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending_lux.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.failures == 0 && tracker.pending_lux.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
